// ===== rtl/hsv_to_rgbw_dimmed_defines.svh =====
// Assertion macros for the HSV to RGBW converter.
// Included by the top level; needs signals named clock and reset in scope.
`ifndef HSV_TO_RGBW_DIMMED_DEFINES_SVH
`define HSV_TO_RGBW_DIMMED_DEFINES_SVH

// Holds at every clock edge outside reset.
`define HSVRGBW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// When cond holds, conseq must hold in the next cycle.
`define HSVRGBW_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== rtl/hsvrgbw_pkg.sv =====
// Shared types and constants of the HSV to RGBW converter.
// No dependencies; used by hsvrgbw_level_calc and the top level.
package hsvrgbw_pkg;

   localparam int unsigned LevelWidth   = 8;
   localparam int unsigned HueWidth     = 11;
   localparam int unsigned CurveDepth   = 256;
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 32;

   localparam logic [HueWidth-1:0] HueMax = 11'd1535;

   localparam logic KindConvert = 1'b0;
   localparam logic KindLoad    = 1'b1;

   typedef logic [LevelWidth-1:0] level_type;

   typedef struct packed {
      logic                kind;
      logic [HueWidth-1:0] hue;
      level_type           saturation;
      level_type           brightness;
      level_type           curve_index;
      level_type           curve_value;
   } req_type;

   // Everything the curve lookup stage needs for one word.
   typedef struct packed {
      logic       load;
      level_type  wr_addr;
      level_type  wr_data;
      logic       bad;
      logic       black;
      logic       grey;
      logic [2:0] sextant;
      level_type  brightness;
      level_type  top_addr;
      level_type  bot_addr;
      level_type  ramp_addr;
   } lvl_type;

endpackage

// ===== rtl/hsvrgbw_curve_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds one copy of the dimming curve.
module hsvrgbw_curve_ram #(
   parameter int unsigned AddrWidth = 8,
   parameter int unsigned DataWidth = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [DataWidth-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [DataWidth-1:0] rd_data
);

   logic [DataWidth-1:0] mem [(2**AddrWidth)-1:0];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hsvrgbw_level_calc.sv =====
// Two-stage address pipeline: computes the top, bottom and ramping curve addresses.
// Depends on hsvrgbw_pkg.
module hsvrgbw_level_calc (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  hsvrgbw_pkg::req_type in_item,
   output logic                 out_valid,
   output hsvrgbw_pkg::lvl_type out_lvl
);
   import hsvrgbw_pkg::*;

   logic      a_valid_ff;
   req_type   a_item_ff;
   logic      a_bad_ff;
   logic [15:0] a_t_ff;
   logic [15:0] a_u_ff;
   logic [15:0] a_t_in;
   logic [15:0] a_u_in;
   logic [15:0] t_prod;
   logic [15:0] u_prod;
   logic [8:0]  rise_factor;
   logic [8:0]  ramp_factor;

   logic        b_valid_ff;
   lvl_type     b_lvl_ff;
   lvl_type     b_lvl_in;
   logic [15:0] t_adj;
   logic [15:0] u_adj;
   level_type   q;
   logic [15:0] r_prod;

   // Stage A: the two independent multiplies.
   assign t_prod = {8'd0, in_item.brightness} * {8'd0, 8'hff - in_item.saturation};
   assign a_t_in = t_prod + 16'd1;

   // A rising ramp uses 256 - f, which is 256 itself for a zero fraction.
   assign rise_factor = 9'd256 - {1'b0, in_item.hue[7:0]};
   assign ramp_factor = in_item.hue[8] ? {1'b0, in_item.hue[7:0]} : rise_factor;
   assign u_prod = {8'd0, in_item.saturation} * {7'd0, ramp_factor};
   assign a_u_in = u_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff <= in_item;
         a_bad_ff  <= (in_item.hue > HueMax);
         a_t_ff    <= a_t_in;
         a_u_ff    <= a_u_in;
         b_lvl_ff  <= b_lvl_in;
      end
   end

   // Stage B: error correction and the dependent ramp multiply.
   assign t_adj  = a_t_ff + {8'd0, a_t_ff[15:8]};
   assign u_adj  = a_u_ff + {8'd0, a_u_ff[15:8]};
   assign q      = ~u_adj[15:8];
   assign r_prod = {8'd0, a_item_ff.brightness} * {8'd0, q}
                   + {9'd0, a_item_ff.brightness[7:1]};

   always_comb begin
      b_lvl_in.load       = (a_item_ff.kind == KindLoad);
      b_lvl_in.wr_addr    = a_item_ff.curve_index;
      b_lvl_in.wr_data    = a_item_ff.curve_value;
      b_lvl_in.bad        = a_bad_ff;
      b_lvl_in.black      = (a_item_ff.brightness == '0);
      b_lvl_in.grey       = (a_item_ff.saturation == '0);
      b_lvl_in.sextant    = a_item_ff.hue[10:8];
      b_lvl_in.brightness = a_item_ff.brightness;
      b_lvl_in.top_addr   = a_item_ff.brightness;
      b_lvl_in.bot_addr   = t_adj[15:8];
      b_lvl_in.ramp_addr  = r_prod[15:8];
   end

   assign out_valid = b_valid_ff;
   assign out_lvl   = b_lvl_ff;

endmodule

// ===== rtl/hsv_to_rgbw_dimmed.sv =====
// Channel | Dir | tdata (low bit up)                                   | tuser
// req     | in  | hue, saturation, brightness, curve_index, curve_value | kind
// rsp     | out | red, green, blue, white                               | hue_invalid
//
// One word is accepted per cycle while req_tready is high. A color result passes two
// address stages, the curve RAM read and the output register, the first of them loaded
// at the edge that takes its word.
// The curve lives in three RAM copies, one per level, each written by every load word
// in the same stage where the converts read, so words see loads in their stream order.
// Reset clears only the valid bits; curve entries are undefined until loaded.
// A two-entry output buffer lets req_tready depend on a register only; it drops only
// while both entries hold words, and then load words wait with the rest.
// Depends on hsvrgbw_pkg, hsvrgbw_level_calc, hsvrgbw_curve_ram and the defines header.
`include "hsv_to_rgbw_dimmed_defines.svh"

module hsv_to_rgbw_dimmed (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // hue[10:0], saturation[18:11], brightness[26:19], curve_index[34:27],
   // curve_value[42:35], zero fill above
   input  logic [hsvrgbw_pkg::ReqDataWidth-1:0] req_tdata,
   // kind[0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // red[7:0], green[15:8], blue[23:16], white[31:24]
   output logic [hsvrgbw_pkg::RspDataWidth-1:0] rsp_tdata,
   // hue_invalid[0]
   output logic                                 rsp_tuser
);
   import hsvrgbw_pkg::*;

   localparam int unsigned CurveAddrWidth = $clog2(CurveDepth);

   req_type   in_item;
   logic      adv;
   logic      b_valid;
   lvl_type   b_lvl;
   logic      c_valid_ff;
   lvl_type   c_lvl_ff;
   level_type top_q;
   level_type bot_q;
   level_type ramp_q;
   logic      ram_we;
   logic      ram_re;

   level_type red;
   level_type green;
   level_type blue;
   level_type white;
   logic      hue_invalid;
   logic      push;
   logic      take;
   logic [RspDataWidth:0] res_word;

   logic                  main_valid_ff;
   logic [RspDataWidth:0] main_word_ff;
   logic                  skid_valid_ff;
   logic [RspDataWidth:0] skid_word_ff;

   assign in_item.kind        = req_tuser;
   assign in_item.hue         = req_tdata[10:0];
   assign in_item.saturation  = req_tdata[18:11];
   assign in_item.brightness  = req_tdata[26:19];
   assign in_item.curve_index = req_tdata[34:27];
   assign in_item.curve_value = req_tdata[42:35];

   // The whole pipeline moves unless the output buffer is full.
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   hsvrgbw_level_calc u_level_calc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_item   (in_item),
      .out_valid (b_valid),
      .out_lvl   (b_lvl)
   );

   assign ram_we = adv && b_valid && b_lvl.load;
   assign ram_re = adv && b_valid && !b_lvl.load;

   hsvrgbw_curve_ram #(
      .AddrWidth (CurveAddrWidth),
      .DataWidth (LevelWidth)
   ) u_top_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (b_lvl.wr_addr),
      .wr_data (b_lvl.wr_data),
      .rd_en   (ram_re),
      .rd_addr (b_lvl.top_addr),
      .rd_data (top_q)
   );

   hsvrgbw_curve_ram #(
      .AddrWidth (CurveAddrWidth),
      .DataWidth (LevelWidth)
   ) u_bot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (b_lvl.wr_addr),
      .wr_data (b_lvl.wr_data),
      .rd_en   (ram_re),
      .rd_addr (b_lvl.bot_addr),
      .rd_data (bot_q)
   );

   hsvrgbw_curve_ram #(
      .AddrWidth (CurveAddrWidth),
      .DataWidth (LevelWidth)
   ) u_ramp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (b_lvl.wr_addr),
      .wr_data (b_lvl.wr_data),
      .rd_en   (ram_re),
      .rd_addr (b_lvl.ramp_addr),
      .rd_data (ramp_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_lvl_ff <= b_lvl;
      end
   end

   // Special cases take priority in this order: bad hue, black, grey.
   always_comb begin
      red         = '0;
      green       = '0;
      blue        = '0;
      white       = '0;
      hue_invalid = 1'b0;
      priority if (c_lvl_ff.bad) begin
         hue_invalid = 1'b1;
      end else if (c_lvl_ff.black) begin
         hue_invalid = 1'b0;
      end else if (c_lvl_ff.grey) begin
         red   = c_lvl_ff.brightness;
         green = c_lvl_ff.brightness;
         blue  = c_lvl_ff.brightness;
         white = c_lvl_ff.brightness;
      end else begin
         white = bot_q;
         unique case (c_lvl_ff.sextant)
            3'd0: begin
               red = top_q;  green = ramp_q; blue = bot_q;
            end
            3'd1: begin
               red = ramp_q; green = top_q;  blue = bot_q;
            end
            3'd2: begin
               red = bot_q;  green = top_q;  blue = ramp_q;
            end
            3'd3: begin
               red = bot_q;  green = ramp_q; blue = top_q;
            end
            3'd4: begin
               red = ramp_q; green = bot_q;  blue = top_q;
            end
            default: begin
               red = top_q;  green = bot_q;  blue = ramp_q;
            end
         endcase
      end
   end

   assign res_word = {hue_invalid, white, blue, green, red};
   assign push     = adv && c_valid_ff && !c_lvl_ff.load;
   assign take     = main_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (push && (!main_valid_ff || take)) begin
            main_valid_ff <= 1'b1;
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end else if (take) begin
            main_valid_ff <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= main_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (push && (!main_valid_ff || take)) begin
         main_word_ff <= res_word;
      end else if (push) begin
         skid_word_ff <= res_word;
      end else if (take && skid_valid_ff) begin
         main_word_ff <= skid_word_ff;
      end else begin
         main_word_ff <= main_word_ff;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_word_ff[RspDataWidth-1:0];
   assign rsp_tuser  = main_word_ff[RspDataWidth];

   `HSVRGBW_ASSERT(a_skid_needs_main, skid_valid_ff |-> main_valid_ff,
                   "skid word without main word")
   `HSVRGBW_ASSERT(a_bad_hue_black, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0),
                   "bad hue with nonzero levels")
   `HSVRGBW_ASSERT_NEXT(a_overflow_to_skid, push && main_valid_ff && !take, skid_valid_ff,
                        "stalled result not parked")

endmodule
